### sv/twrl_pkg.sv
// ----------------------------------------------------------------------------
// twrl_pkg
// Shared types and constants of the trigger window rate limiter.
// ----------------------------------------------------------------------------
package twrl_pkg;

  // Configuration port address width and register indexes (paddr[3:2])
  localparam int unsigned CfgAddrW = 4;
  localparam logic [1:0] REG_WINDOW_SECONDS  = 2'd0;
  localparam logic [1:0] REG_MAX_ACCEPTED    = 2'd1;
  localparam logic [1:0] REG_LOCKOUT_SECONDS = 2'd2;

  // Register reset values
  localparam logic [31:0] WindowSecondsRst  = 32'd3600;
  localparam logic [7:0]  MaxAcceptedRst    = 8'd3;
  localparam logic [31:0] LockoutSecondsRst = 32'd3600;

  // Saturation limits
  localparam logic [15:0] SupMax = 16'hFFFF;
  localparam logic [7:0]  AccMax = 8'hFF;

  // Result decision codes
  typedef enum logic [1:0] {
    DEC_ACCEPT     = 2'd0,
    DEC_LOCKOUT    = 2'd1,
    DEC_RATE_LIMIT = 2'd2
  } decision_e;

  // Input item: one trigger event
  typedef struct packed {
    logic [31:0] now_seconds;
    logic        time_valid;
  } in_item_t;

  // Result item
  typedef struct packed {
    decision_e   decision;
    logic [15:0] suppressed_count;
    logic [7:0]  window_count;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [31:0] window_seconds;
    logic [7:0]  max_accepted;
    logic [31:0] lockout_seconds;
  } cfg_t;

endpackage

### sv/twrl_cfg_regs.sv
// ----------------------------------------------------------------------------
// twrl_cfg_regs
// APB-style register file for window length, limit and lockout length.
// ----------------------------------------------------------------------------
module twrl_cfg_regs import twrl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t        cfg_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_seconds  <= WindowSecondsRst;
      cfg_q.max_accepted    <= MaxAcceptedRst;
      cfg_q.lockout_seconds <= LockoutSecondsRst;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW_SECONDS:  cfg_q.window_seconds  <= pwdata;
        REG_MAX_ACCEPTED:    cfg_q.max_accepted    <= pwdata[7:0];
        REG_LOCKOUT_SECONDS: cfg_q.lockout_seconds <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_WINDOW_SECONDS:  prdata = cfg_q.window_seconds;
      REG_MAX_ACCEPTED:    prdata = {24'd0, cfg_q.max_accepted};
      REG_LOCKOUT_SECONDS: prdata = cfg_q.lockout_seconds;
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### sv/twrl_core.sv
// ----------------------------------------------------------------------------
// twrl_core
// Limiter state and the combinational decision for one registered event.
// ----------------------------------------------------------------------------
module twrl_core import twrl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      step_i,   // event in the input register is retired now
  input  in_item_t  item_i,
  output out_item_t res_o
);

  logic [31:0] win_start_q, win_start_d;
  logic [7:0]  acc_q, acc_d;
  logic [31:0] lock_until_q, lock_until_d;
  logic [15:0] sup_q, sup_d;

  logic        lock_active;
  logic        new_win;
  logic [31:0] elapsed;
  logic [7:0]  acc_base;
  logic [7:0]  acc_inc;
  logic [32:0] lock_sum;
  logic [31:0] lock_end;
  logic [15:0] sup_inc;

  // Condition terms
  assign lock_active = (lock_until_q != 32'd0) && (item_i.now_seconds < lock_until_q);
  assign elapsed     = item_i.now_seconds - win_start_q;
  assign new_win     = (win_start_q == 32'd0) || (item_i.now_seconds < win_start_q) ||
                       (elapsed >= cfg_i.window_seconds);
  assign acc_base    = new_win ? 8'd0 : acc_q;
  assign acc_inc     = (acc_base == AccMax) ? acc_base : acc_base + 8'd1;
  assign lock_sum    = {1'b0, item_i.now_seconds} + {1'b0, cfg_i.lockout_seconds};
  assign lock_end    = lock_sum[32] ? 32'hFFFF_FFFF : lock_sum[31:0];
  assign sup_inc     = (sup_q == SupMax) ? sup_q : sup_q + 16'd1;

  // Decision and next state
  always_comb begin
    win_start_d  = win_start_q;
    acc_d        = acc_q;
    lock_until_d = lock_until_q;
    sup_d        = 16'd0;
    res_o.decision         = DEC_ACCEPT;
    res_o.suppressed_count = sup_q;
    res_o.window_count     = acc_q;
    if (item_i.time_valid) begin
      if (lock_active) begin
        sup_d = sup_inc;
        res_o.decision         = DEC_LOCKOUT;
        res_o.suppressed_count = sup_inc;
      end else begin
        win_start_d = new_win ? item_i.now_seconds : win_start_q;
        if (acc_base >= cfg_i.max_accepted) begin
          acc_d        = acc_base;
          lock_until_d = lock_end;
          sup_d        = sup_inc;
          res_o.decision         = DEC_RATE_LIMIT;
          res_o.suppressed_count = sup_inc;
          res_o.window_count     = acc_base;
        end else begin
          acc_d        = acc_inc;
          lock_until_d = 32'd0;
          res_o.window_count = acc_inc;
        end
      end
    end
  end

  // State registers, updated once per retired event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q  <= 32'd0;
      acc_q        <= 8'd0;
      lock_until_q <= 32'd0;
      sup_q        <= 16'd0;
    end else if (step_i) begin
      win_start_q  <= win_start_d;
      acc_q        <= acc_d;
      lock_until_q <= lock_until_d;
      sup_q        <= sup_d;
    end
  end

  // Accepted event always clears the suppressed counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res_o.decision == DEC_ACCEPT) |=> sup_q == 16'd0)
    else $error("suppressed count not cleared after accept");

  // Rate limit only fires with the window count at or above the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res_o.decision == DEC_RATE_LIMIT) |->
      res_o.window_count >= cfg_i.max_accepted)
    else $error("rate limit below max_accepted");

  // Accept with valid time drops any lockout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.time_valid && (res_o.decision == DEC_ACCEPT) |=>
      lock_until_q == 32'd0)
    else $error("lockout survived an accepted event");

  // Suppression never decreases the counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res_o.decision != DEC_ACCEPT) |=> sup_q >= $past(sup_q))
    else $error("suppressed count decreased on suppress");

endmodule

### sv/trigger_window_rate_limiter.sv
// ----------------------------------------------------------------------------
// trigger_window_rate_limiter
// Fixed-window trigger rate limiter with lockout, one result per event.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_stall_o/in_item_i carries one trigger event
//   (time in seconds plus a time-valid flag). Output channel
//   out_valid_o/out_stall_i/out_item_o returns exactly one result per event:
//   the decision, the suppressed-event count and the window count.
//   An item is taken at a clock edge with valid high and stall low.
//   An event taken into the input register is decided there, and its result
//   is registered in the result register when that register is free.
//   Throughput: one event per cycle while the receiver does not stall; the decision is a
//   single pass of compares, a 32-bit add, a 32-bit subtract and counter updates between the two registers.
//   The result register frees up in the same cycle it is taken, so a stalled
//   receiver holds both registers and in_stall_o rises only when both are full.
//   Reset (rst_ni, async, low) empties both stages, clears the window,
//   lockout and counters, and loads the register defaults.
//   Configuration goes through the APB-style port (window length at 0x0,
//   limit at 0x4, lockout length at 0x8) while the block is idle.
// ----------------------------------------------------------------------------
module trigger_window_rate_limiter import twrl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  // Output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t      cfg;
  in_item_t  s1_item_q;
  logic      s1_valid_q;
  out_item_t res;
  out_item_t out_item_q;
  logic      out_valid_q;
  logic      out_free;
  logic      step;
  logic      in_take;

  // Handshake: the input register moves on whenever the result register is free
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  twrl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  twrl_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .item_i (s1_item_q),
    .res_o  (res)
  );

  // Input register: holds its item until it is retired into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_take || (s1_valid_q && !step);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### sim/twrl_decision_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twrl_decision_tracker
// Watches the trigger and result channels of the rate limiter, keeps its own
// copy of window, lockout and counters, and checks every result in order.
// Configuration is followed by snooping the APB-style port; reads of the
// registers are checked against that copy.
// ----------------------------------------------------------------------------
module twrl_decision_tracker import twrl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Trigger channel
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_item_i,
  // Result channel
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_item_i,
  // Configuration port
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic [31:0]         prdata_i,
  input  logic                pready_i,
  // Status toward the testbench top
  output int unsigned         errors_o,
  output int unsigned         pending_o
);

  // Shadow configuration and limiter state
  cfg_t        cfg_shadow;
  logic [31:0] win_start;
  logic [7:0]  win_accepted;
  logic [31:0] lock_end;
  logic [15:0] sup_total;

  out_item_t   due_results[$];
  int unsigned err_cnt;

  task automatic note_fault(input string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic void bump_suppressed();
    if (sup_total != SupMax) begin
      sup_total++;
    end
  endfunction

  // Decision for one trigger event; updates the shadow state
  function automatic out_item_t judge_trigger(input in_item_t ev);
    out_item_t   res;
    logic [32:0] lock_sum;
    res.decision         = DEC_ACCEPT;
    res.suppressed_count = '0;
    res.window_count     = '0;
    if (ev.time_valid && lock_end != '0 && ev.now_seconds < lock_end) begin
      // still locked out: window untouched
      bump_suppressed();
      res.decision         = DEC_LOCKOUT;
      res.suppressed_count = sup_total;
      res.window_count     = win_accepted;
    end else begin
      if (ev.time_valid) begin
        // reopen the window when unset, in the future or expired
        if (win_start == '0 || ev.now_seconds < win_start ||
            (ev.now_seconds - win_start) >= cfg_shadow.window_seconds) begin
          win_start    = ev.now_seconds;
          win_accepted = '0;
          lock_end     = '0;
        end
      end
      if (ev.time_valid && win_accepted >= cfg_shadow.max_accepted) begin
        // rate limit hit: start a lockout, end time saturates
        lock_sum = {1'b0, ev.now_seconds} + {1'b0, cfg_shadow.lockout_seconds};
        lock_end = lock_sum[32] ? 32'hFFFF_FFFF : lock_sum[31:0];
        bump_suppressed();
        res.decision         = DEC_RATE_LIMIT;
        res.suppressed_count = sup_total;
        res.window_count     = win_accepted;
      end else begin
        if (ev.time_valid) begin
          if (win_accepted != AccMax) begin
            win_accepted++;
          end
          lock_end = '0;
        end
        res.decision         = DEC_ACCEPT;
        res.suppressed_count = sup_total;
        res.window_count     = win_accepted;
        sup_total            = '0;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t   want;
    logic [31:0] reg_val;
    if (!rst_ni) begin
      cfg_shadow.window_seconds  = WindowSecondsRst;
      cfg_shadow.max_accepted    = MaxAcceptedRst;
      cfg_shadow.lockout_seconds = LockoutSecondsRst;
      win_start    = '0;
      win_accepted = '0;
      lock_end     = '0;
      sup_total    = '0;
      due_results.delete();
      err_cnt      = 0;
    end else begin
      // result side first: a result never belongs to this edge's trigger
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          note_fault($sformatf("unexpected result: dec=%0d sup=%0d win=%0d",
                               out_item_i.decision, out_item_i.suppressed_count,
                               out_item_i.window_count));
        end else begin
          want = due_results.pop_front();
          if (out_item_i.decision !== want.decision ||
              out_item_i.suppressed_count !== want.suppressed_count ||
              out_item_i.window_count !== want.window_count) begin
            note_fault($sformatf(
              "result mismatch: exp dec=%0d sup=%0d win=%0d, got dec=%0d sup=%0d win=%0d",
              want.decision, want.suppressed_count, want.window_count,
              out_item_i.decision, out_item_i.suppressed_count,
              out_item_i.window_count));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due_results.push_back(judge_trigger(in_item_i));
      end
      // register writes and read-back; unused indexes read as zero
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i[3:2])
            REG_WINDOW_SECONDS:  cfg_shadow.window_seconds  = pwdata_i;
            REG_MAX_ACCEPTED:    cfg_shadow.max_accepted    = pwdata_i[7:0];
            REG_LOCKOUT_SECONDS: cfg_shadow.lockout_seconds = pwdata_i;
            default: ;
          endcase
        end else begin
          case (paddr_i[3:2])
            REG_WINDOW_SECONDS:  reg_val = cfg_shadow.window_seconds;
            REG_MAX_ACCEPTED:    reg_val = {24'd0, cfg_shadow.max_accepted};
            REG_LOCKOUT_SECONDS: reg_val = cfg_shadow.lockout_seconds;
            default:             reg_val = 32'd0;
          endcase
          if (prdata_i !== reg_val) begin
            note_fault($sformatf("register read mismatch at %0h: exp %0h got %0h",
                                 paddr_i, reg_val, prdata_i));
          end
        end
      end
    end
    errors_o  = err_cnt;
    pending_o = due_results.size();
  end

endmodule

### sim/trigger_window_rate_limiter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trigger_window_rate_limiter_tb
// Drives trigger events and register settings into the rate limiter and
// leaves prediction and comparison to the tracker beside it. A directed
// opening covers time zero, lockout end saturation and the zero settings;
// random phases then walk time forward under several window, limit and
// lockout settings with idle bursts on both sides, and a closing run of
// locked-out events without idling grows the suppressed count.
// ----------------------------------------------------------------------------
module trigger_window_rate_limiter_tb;
  import twrl_pkg::*;

  localparam int          ClkPeriod   = 4;
  localparam int          HoldCycles  = 64;
  localparam int          SatItems    = 40;
  localparam logic [1:0]  RegUnused   = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned         fail_cnt;
  int unsigned         results_due;
  bit                  idle_on       = 1'b1;
  bit                  long_hold_req = 1'b0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  trigger_window_rate_limiter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  twrl_decision_tracker tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .errors_o    (fail_cnt),
    .pending_o   (results_due)
  );

  // One trigger event; returns at the edge that takes it
  task automatic push_trigger(input logic [31:0] now, input logic valid);
    if (idle_on && !long_hold_req && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i              <= 1'b1;
    in_item_i.now_seconds   <= now;
    in_item_i.time_valid    <= valid;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // APB setup and access cycles
  task automatic cfg_access(input logic wr, input logic [1:0] idx,
                            input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain, then load and read back a full register set
  task automatic reconfigure(input logic [31:0] win, input logic [7:0] lim,
                             input logic [31:0] lock);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (results_due == 0);
    cfg_access(1'b1, REG_WINDOW_SECONDS, win);
    cfg_access(1'b1, REG_MAX_ACCEPTED, {24'd0, lim});
    cfg_access(1'b1, REG_LOCKOUT_SECONDS, lock);
    cfg_access(1'b0, REG_WINDOW_SECONDS, '0);
    cfg_access(1'b0, REG_MAX_ACCEPTED, '0);
    cfg_access(1'b0, REG_LOCKOUT_SECONDS, '0);
  endtask

  // Random phase: mostly a forward time walk, with noise and backward steps
  task automatic run_phase(input logic [31:0] win, input logic [7:0] lim,
                           input logic [31:0] lock, input int unsigned n,
                           input int unsigned step_max, input bit with_hold);
    logic [31:0] cur;
    int unsigned pick;
    reconfigure(win, lim, lock);
    pick = $urandom_range(0, 3);
    if (pick < 2) begin
      cur = $urandom_range(0, 100);
    end else if (pick == 2) begin
      cur = $urandom;
    end else begin
      cur = 32'hFFFF_FFFF - $urandom_range(0, 200);
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (with_hold && i == n / 2) begin
        long_hold_req = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_trigger($urandom, 1'b0);
      end else if (pick < 12) begin
        push_trigger($urandom, 1'b1);
      end else if (pick < 15) begin
        push_trigger(cur - $urandom_range(1, step_max + 1), 1'b1);
      end else begin
        cur = cur + $urandom_range(0, step_max);
        push_trigger(cur, 1'b1);
      end
    end
  endtask

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i   <= 1'b0;
        long_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Run limit
  initial begin
    #(ClkPeriod * 500000);
    $display("trigger_window_rate_limiter_tb: errors");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default settings: window at time zero, fill, rate limit, lockout
    push_trigger(32'd0, 1'b1);
    push_trigger(32'd1, 1'b1);
    push_trigger(32'd2, 1'b1);
    push_trigger(32'd3, 1'b1);
    push_trigger(32'd4, 1'b1);
    push_trigger(32'd100, 1'b1);
    push_trigger(32'hFFFF_FFFF, 1'b0);
    push_trigger(32'd3604, 1'b1);
    push_trigger(32'd0, 1'b1);
    // lockout end saturates near the top of time
    push_trigger(32'hFFFF_FF00, 1'b1);
    push_trigger(32'hFFFF_FF01, 1'b1);
    push_trigger(32'hFFFF_FF02, 1'b1);
    push_trigger(32'hFFFF_FFF0, 1'b1);
    push_trigger(32'hFFFF_FFFE, 1'b1);
    push_trigger(32'hFFFF_FFFF, 1'b1);
    push_trigger(32'h5555_AAAA, 1'b0);

    // zero window length: every timed event reopens
    reconfigure(32'd0, 8'd255, 32'd0);
    push_trigger(32'd10, 1'b1);
    push_trigger(32'd10, 1'b1);

    // zero limit with zero lockout: lockout ending at time zero
    reconfigure(32'd1, 8'd0, 32'd0);
    push_trigger(32'd0, 1'b1);
    push_trigger(32'd0, 1'b1);
    push_trigger(32'd7, 1'b0);
    // write to an unused register is ignored; drain first
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (results_due == 0);
    cfg_access(1'b1, RegUnused, $urandom);
    push_trigger(32'd9, 1'b1);

    // Random phases across settings, extremes included
    run_phase(32'd10, 8'd3, 32'd5, 200, 3, 1'b0);
    run_phase(32'd1, 8'd1, 32'd1, 180, 2, 1'b1);
    run_phase(32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, 320, 1, 1'b0);
    run_phase(32'd100, 8'd8, 32'd20, 200, 12, 1'b0);
    run_phase(32'd0, 8'd2, 32'd3, 120, 2, 1'b0);
    run_phase($urandom_range(1, 40), 8'($urandom_range(0, 6)), $urandom_range(0, 30),
              200, 6, 1'b0);
    run_phase(32'd25, 8'd0, 32'd4, 120, 5, 1'b0);

    // Last part without idling: one rate limit, then a run of locked-out events
    idle_on = 1'b0;
    reconfigure(32'hFFFF_FFFF, 8'd0, 32'hFFFF_FFFF);
    push_trigger(32'd10, 1'b1);
    for (int i = 0; i < SatItems; i++) begin
      push_trigger($urandom_range(0, 32'hFFFF_FFFE), 1'b1);
    end
    push_trigger($urandom, 1'b0);
    run_phase(32'd30, 8'd4, 32'd10, 150, 4, 1'b0);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (results_due == 0);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && results_due == 0) begin
      $display("trigger_window_rate_limiter_tb: clean");
    end else begin
      $display("trigger_window_rate_limiter_tb: errors");
    end
    $finish;
  end

endmodule

### trigger_window_rate_limiter.f
sv/twrl_pkg.sv
sv/twrl_cfg_regs.sv
sv/twrl_core.sv
sv/trigger_window_rate_limiter.sv
sim/twrl_decision_tracker.sv
sim/trigger_window_rate_limiter_tb.sv
